[rtl/sled_pkg.sv]
package sled_pkg;

  localparam int unsigned CHAR_W = 21;
  localparam int unsigned CODE_W = 24;
  localparam int unsigned LEFT_W = 3;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_ESCAPE = 2'd1,
    MODE_HEX    = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ERR_NONE = 2'd0,
    ERR_EOF  = 2'd1,
    ERR_BAD  = 2'd2
  } err_t;

  localparam logic [CHAR_W-1:0] CH_LF     = 21'h00000A;
  localparam logic [CHAR_W-1:0] CH_QUOTE  = 21'h000022;
  localparam logic [CHAR_W-1:0] CH_ZERO   = 21'h000030;
  localparam logic [CHAR_W-1:0] CH_BIG_U  = 21'h000055;
  localparam logic [CHAR_W-1:0] CH_BSLASH = 21'h00005C;
  localparam logic [CHAR_W-1:0] CH_A      = 21'h000061;
  localparam logic [CHAR_W-1:0] CH_B      = 21'h000062;
  localparam logic [CHAR_W-1:0] CH_F      = 21'h000066;
  localparam logic [CHAR_W-1:0] CH_N      = 21'h00006E;
  localparam logic [CHAR_W-1:0] CH_R      = 21'h000072;
  localparam logic [CHAR_W-1:0] CH_T      = 21'h000074;
  localparam logic [CHAR_W-1:0] CH_U      = 21'h000075;
  localparam logic [CHAR_W-1:0] CH_V      = 21'h000076;
  localparam logic [CHAR_W-1:0] CH_X      = 21'h000078;

  localparam logic [CODE_W-1:0] CODE_BEL = 24'd7;
  localparam logic [CODE_W-1:0] CODE_BS  = 24'd8;
  localparam logic [CODE_W-1:0] CODE_TAB = 24'd9;
  localparam logic [CODE_W-1:0] CODE_LF  = 24'd10;
  localparam logic [CODE_W-1:0] CODE_VT  = 24'd11;
  localparam logic [CODE_W-1:0] CODE_FF  = 24'd12;
  localparam logic [CODE_W-1:0] CODE_CR  = 24'd13;

  localparam logic [LEFT_W-1:0] LEFT_X     = 3'd2;
  localparam logic [LEFT_W-1:0] LEFT_SMALL = 3'd4;
  localparam logic [LEFT_W-1:0] LEFT_BIG   = 3'd6;

  typedef struct packed {
    mode_t             mode;
    logic [LEFT_W-1:0] left;
    logic [CODE_W-1:0] value;
  } state_t;

  typedef struct packed {
    logic              char_valid;
    logic [CODE_W-1:0] code_point;
    logic              done_res;
    err_t              error_code;
  } res_t;

  localparam state_t STATE_RESET = '{mode: MODE_NORMAL, left: '0, value: '0};

endpackage

[rtl/sled_decode.sv]
module sled_decode (
  input  sled_pkg::state_t                  st,
  input  logic [sled_pkg::CHAR_W-1:0]       ch,
  input  logic                              at_end,
  output sled_pkg::state_t                  st_nxt,
  output sled_pkg::res_t                    res
);
  import sled_pkg::*;

  logic [3:0]        digit;
  logic              digit_ok;
  logic [LEFT_W-1:0] left_dec;
  logic [CODE_W-1:0] value_sh;

  // hex digit, either case
  always_comb begin
    digit    = '0;
    digit_ok = 1'b0;
    if (ch >= 21'h30 && ch <= 21'h39) begin
      digit    = ch[3:0];
      digit_ok = 1'b1;
    end else if ((ch >= 21'h41 && ch <= 21'h46) || (ch >= 21'h61 && ch <= 21'h66)) begin
      digit    = ch[3:0] + 4'd9;
      digit_ok = 1'b1;
    end
  end

  assign left_dec = st.left - 3'd1;
  assign value_sh = {st.value[CODE_W-5:0], digit};

  always_comb begin
    st_nxt = st;
    res    = '{char_valid: 1'b0, code_point: '0, done_res: 1'b0, error_code: ERR_NONE};
    if (at_end) begin
      st_nxt         = STATE_RESET;
      res.done_res   = 1'b1;
      res.error_code = ERR_EOF;
    end else begin
      case (st.mode)
        MODE_ESCAPE: begin
          st_nxt.mode    = MODE_NORMAL;
          res.char_valid = 1'b1;
          case (ch)
            CH_QUOTE:  res.code_point = {3'b000, CH_QUOTE};
            CH_BSLASH: res.code_point = {3'b000, CH_BSLASH};
            CH_ZERO:   res.code_point = '0;
            CH_F:      res.code_point = CODE_FF;
            CH_N:      res.code_point = CODE_LF;
            CH_R:      res.code_point = CODE_CR;
            CH_T:      res.code_point = CODE_TAB;
            CH_A:      res.code_point = CODE_BEL;
            CH_V:      res.code_point = CODE_VT;
            CH_B:      res.code_point = CODE_BS;
            CH_LF:     res.char_valid = 1'b0;
            CH_X, CH_U, CH_BIG_U: begin
              res.char_valid = 1'b0;
              st_nxt.mode    = MODE_HEX;
              st_nxt.value   = '0;
              st_nxt.left    = (ch == CH_X) ? LEFT_X : (ch == CH_U) ? LEFT_SMALL : LEFT_BIG;
            end
            default: begin
              res.char_valid = 1'b0;
              res.done_res   = 1'b1;
              res.error_code = ERR_BAD;
              st_nxt         = STATE_RESET;
            end
          endcase
        end
        MODE_HEX: begin
          if (!digit_ok) begin
            res.done_res   = 1'b1;
            res.error_code = ERR_BAD;
            st_nxt         = STATE_RESET;
          end else if (left_dec == '0) begin
            res.char_valid = 1'b1;
            res.code_point = value_sh;
            st_nxt         = STATE_RESET;
          end else begin
            st_nxt.value = value_sh;
            st_nxt.left  = left_dec;
          end
        end
        default: begin
          st_nxt.mode = MODE_NORMAL;
          if (ch == CH_QUOTE) begin
            st_nxt       = STATE_RESET;
            res.done_res = 1'b1;
          end else if (ch == CH_BSLASH) begin
            st_nxt.mode = MODE_ESCAPE;
          end else begin
            res.char_valid = 1'b1;
            res.code_point = {3'b000, ch};
          end
        end
      endcase
    end
  end

endmodule

[rtl/string_literal_escape_decoder.sv]
// String literal escape decoder. Feed the characters of a literal one per
// transfer, starting after the opening quote; every input transfer yields
// exactly one result transfer, in order. A result carries a decoded code
// point (out_char_valid), nothing (escape prefixes, hex digits before the
// last, backslash-newline), or the end of the literal (out_done_res) with
// out_error_code 0 for a closing quote, 1 for end of input and 2 for a bad
// escape. One item is taken every cycle; an input register is followed
// by a result register, and the decode state is updated as the result
// register loads. Back-pressure on the result side stalls the input only
// when both registers are full.
module string_literal_escape_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [sled_pkg::CHAR_W-1:0]   in_char,
  input  logic                          in_at_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_char_valid,
  output logic [sled_pkg::CODE_W-1:0]   out_code_point,
  output logic                          out_done_res,
  output logic [1:0]                    out_error_code
);
  import sled_pkg::*;

  logic              in_vld_r;
  logic [CHAR_W-1:0] char_r;
  logic              at_end_r;
  logic              out_vld_r;
  res_t              res_r;
  state_t            state_r;
  state_t            state_nxt;
  res_t              res_nxt;
  logic              adv;

  assign adv      = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || adv;

  sled_decode u_decode (
    .st     (state_r),
    .ch     (char_r),
    .at_end (at_end_r),
    .st_nxt (state_nxt),
    .res    (res_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= STATE_RESET;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (adv) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      char_r   <= in_char;
      at_end_r <= in_at_end;
    end
    if (adv) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_char_valid = res_r.char_valid;
  assign out_code_point = res_r.code_point;
  assign out_done_res   = res_r.done_res;
  assign out_error_code = res_r.error_code;

`ifndef SYNTH
  a_char_not_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> !(res_r.char_valid && res_r.done_res))
    else $error("decoded character flagged as end of literal");

  a_err_implies_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && (res_r.error_code != ERR_NONE) |-> res_r.done_res)
    else $error("error reported without end of literal");

  a_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !res_r.char_valid |-> (res_r.code_point == '0))
    else $error("code point set without a character");

  a_hex_left: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r.mode == MODE_HEX) |-> (state_r.left != '0))
    else $error("hex mode with no digits left");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    adv && res_nxt.done_res |=> (state_r == STATE_RESET))
    else $error("state not cleared after end of literal");
`endif

endmodule

[test/tb_string_literal_escape_decoder.sv]
module tb_string_literal_escape_decoder;
  import sled_pkg::*;

  localparam int unsigned N_ITEMS     = 1500;
  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned HOLD_CYCLES = 80;

  localparam logic [CHAR_W-1:0] CH_BIG_A = 21'h000041;
  localparam logic [CHAR_W-1:0] CH_BIG_F = 21'h000046;
  localparam logic [CHAR_W-1:0] CH_G     = 21'h000067;
  localparam logic [CHAR_W-1:0] CH_Q     = 21'h000071;
  localparam logic [CHAR_W-1:0] CH_FOUR  = 21'h000034;
  localparam logic [CHAR_W-1:0] CH_MAX   = 21'h1FFFFF;

  class decode_scoreboard;
    mode_t             mode;
    logic [LEFT_W-1:0] digits_left;
    logic [CODE_W-1:0] acc;
    res_t              pending_codes[$];
    int                fails;

    function new();
      clear();
      fails = 0;
    endfunction

    function void clear();
      mode        = MODE_NORMAL;
      digits_left = '0;
      acc         = '0;
    endfunction

    // digit value, or 16 for anything that is not a hex digit
    function logic [4:0] nibble(logic [CHAR_W-1:0] ch);
      if (ch >= CH_ZERO && ch <= CH_ZERO + 9) return 5'(ch - CH_ZERO);
      if (ch >= CH_BIG_A && ch <= CH_BIG_F) return 5'(ch - CH_BIG_A + 10);
      if (ch >= CH_A && ch <= CH_F) return 5'(ch - CH_A + 10);
      return 5'd16;
    endfunction

    function void note_char(logic [CHAR_W-1:0] ch, logic at_end);
      res_t       r;
      logic [4:0] d;
      r = '0;
      if (at_end) begin
        clear();
        r.done_res   = 1'b1;
        r.error_code = ERR_EOF;
      end else begin
        case (mode)
          MODE_ESCAPE: begin
            mode         = MODE_NORMAL;
            r.char_valid = 1'b1;
            case (ch)
              CH_QUOTE, CH_BSLASH: r.code_point = {3'b000, ch};
              CH_LF:     r.char_valid = 1'b0;
              CH_ZERO:   r.code_point = '0;
              CH_F:      r.code_point = CODE_FF;
              CH_N:      r.code_point = CODE_LF;
              CH_R:      r.code_point = CODE_CR;
              CH_T:      r.code_point = CODE_TAB;
              CH_A:      r.code_point = CODE_BEL;
              CH_V:      r.code_point = CODE_VT;
              CH_B:      r.code_point = CODE_BS;
              CH_X, CH_U, CH_BIG_U: begin
                r.char_valid = 1'b0;
                mode         = MODE_HEX;
                acc          = '0;
                digits_left  = (ch == CH_X) ? LEFT_X : (ch == CH_U) ? LEFT_SMALL : LEFT_BIG;
              end
              default: begin
                clear();
                r            = '0;
                r.done_res   = 1'b1;
                r.error_code = ERR_BAD;
              end
            endcase
          end
          MODE_HEX: begin
            d = nibble(ch);
            if (d > 5'd15) begin
              clear();
              r.done_res   = 1'b1;
              r.error_code = ERR_BAD;
            end else begin
              acc         = {acc[CODE_W-5:0], d[3:0]};
              digits_left = digits_left - 1'b1;
              if (digits_left == '0) begin
                r.char_valid = 1'b1;
                r.code_point = acc;
                clear();
              end
            end
          end
          default: begin
            mode = MODE_NORMAL;
            if (ch == CH_QUOTE) begin
              clear();
              r.done_res = 1'b1;
            end else if (ch == CH_BSLASH) begin
              mode = MODE_ESCAPE;
            end else begin
              r.char_valid = 1'b1;
              r.code_point = {3'b000, ch};
            end
          end
        endcase
      end
      pending_codes.push_back(r);
    endfunction

    function void check_code(res_t got);
      res_t want;
      if (pending_codes.size() == 0) begin
        $error("result transfer with nothing expected: %h", got);
        fails++;
        return;
      end
      want = pending_codes.pop_front();
      if (got.char_valid !== want.char_valid) begin
        $error("char_valid: expected %0d, got %0d", want.char_valid, got.char_valid);
        fails++;
      end
      if (got.code_point !== want.code_point) begin
        $error("code_point: expected %h, got %h", want.code_point, got.code_point);
        fails++;
      end
      if (got.done_res !== want.done_res) begin
        $error("done_res: expected %0d, got %0d", want.done_res, got.done_res);
        fails++;
      end
      if (got.error_code !== want.error_code) begin
        $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
        fails++;
      end
    endfunction

    function void check_leftovers();
      if (pending_codes.size() != 0) begin
        $error("%0d expected results never arrived", pending_codes.size());
        fails++;
      end
    endfunction
  endclass

  logic              clk = 1'b0;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [CHAR_W-1:0] in_char;
  logic              in_at_end;
  logic              out_valid;
  logic              out_ready;
  logic              out_char_valid;
  logic [CODE_W-1:0] out_code_point;
  logic              out_done_res;
  logic [1:0]        out_error_code;

  decode_scoreboard board;
  int unsigned      items_sent = 0;
  int unsigned      burst_left = 0;
  int unsigned      cycle_count = 0;
  bit               hold_req = 1'b0;

  logic [CHAR_W-1:0] simple_escapes[11] = '{CH_QUOTE, CH_BSLASH, CH_LF, CH_ZERO, CH_F,
                                            CH_N, CH_R, CH_T, CH_A, CH_V, CH_B};
  logic [CHAR_W-1:0] near_hex[6] = '{21'h2F, 21'h3A, 21'h40, 21'h47, 21'h60, CH_G};

  string_literal_escape_decoder dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_char        (in_char),
    .in_at_end      (in_at_end),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_char_valid (out_char_valid),
    .out_code_point (out_code_point),
    .out_done_res   (out_done_res),
    .out_error_code (out_error_code)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit is_escape_letter(logic [CHAR_W-1:0] ch);
    foreach (simple_escapes[i]) if (ch == simple_escapes[i]) return 1'b1;
    return ch == CH_X || ch == CH_U || ch == CH_BIG_U;
  endfunction

  function automatic logic [CHAR_W-1:0] hex_char(int unsigned v);
    if (v < 10) return CHAR_W'(CH_ZERO + v);
    return CHAR_W'(($urandom_range(0, 1) ? CH_BIG_A : CH_A) + v - 10);
  endfunction

  function automatic logic [CHAR_W-1:0] plain_char();
    int unsigned k;
    k = $urandom_range(0, 9);
    if (k < 7) return CHAR_W'($urandom_range(32, 126));
    if (k == 7) return CHAR_W'($urandom_range(0, 31));
    return CHAR_W'($urandom);
  endfunction

  task automatic send_item(input logic [CHAR_W-1:0] ch, input logic at_end);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(0, 7) == 0 ? $urandom_range(50, 200) : $urandom_range(1, 20);
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid  <= 1'b1;
    in_char   <= ch;
    in_at_end <= at_end;
    do @(posedge clk); while (!in_ready);
    board.note_char(ch, at_end);
    items_sent++;
  endtask

  task automatic drain_results();
    in_valid   <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (board.pending_codes.size() != 0);
  endtask

  task automatic send_hex_escape(input bit corrupt, input bit cut);
    int unsigned      n;
    int unsigned      bad_at;
    logic [CHAR_W-1:0] ch;
    case ($urandom_range(0, 2))
      0: begin ch = CH_X; n = 2; end
      1: begin ch = CH_U; n = 4; end
      default: begin ch = CH_BIG_U; n = 6; end
    endcase
    send_item(CH_BSLASH, 1'b0);
    send_item(ch, 1'b0);
    bad_at = $urandom_range(0, n - 1);
    for (int unsigned i = 0; i < n; i++) begin
      if (cut && i == bad_at) begin
        send_item(CHAR_W'($urandom), 1'b1);
        return;
      end
      if (corrupt && i == bad_at) begin
        if ($urandom_range(0, 1)) begin
          ch = near_hex[$urandom_range(0, 5)];
        end else begin
          do ch = CHAR_W'($urandom); while (board.nibble(ch) <= 5'd15);
        end
        send_item(ch, 1'b0);
        return;
      end
      send_item(hex_char($urandom_range(0, 15)), 1'b0);
    end
  endtask

  task automatic send_random_piece();
    int unsigned      k;
    logic [CHAR_W-1:0] ch;
    k = $urandom_range(0, 99);
    if (k < 40) begin
      send_item(plain_char(), 1'b0);
    end else if (k < 58) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(simple_escapes[$urandom_range(0, 10)], 1'b0);
    end else if (k < 74) begin
      send_hex_escape($urandom_range(0, 9) == 0, 1'b0);
    end else if (k < 82) begin
      send_item(CH_QUOTE, 1'b0);
    end else if (k < 87) begin
      send_item(CHAR_W'($urandom), 1'b1);
    end else if (k < 94) begin
      send_item(CH_BSLASH, 1'b0);
      do ch = $urandom_range(0, 1) ? plain_char() : CHAR_W'($urandom);
      while (is_escape_letter(ch));
      send_item(ch, 1'b0);
    end else if (k < 97) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(CHAR_W'($urandom), 1'b1);
    end else begin
      send_hex_escape(1'b0, 1'b1);
    end
  endtask

  // receiver: changing stall styles plus one long hold-off on request
  initial begin
    int unsigned style;
    int unsigned style_left;
    style      = 0;
    style_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (style_left == 0) begin
          style      = $urandom_range(0, 3);
          style_left = $urandom_range(20, 200);
        end
        style_left--;
        case (style)
          0: out_ready <= 1'b1;
          1: out_ready <= 1'($urandom_range(0, 1));
          2: out_ready <= $urandom_range(0, 3) == 0;
          default: out_ready <= (style_left % 3) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_code({out_char_valid, out_code_point, out_done_res, out_error_code});
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int unsigned next_drain;
    bit          hold_done;
    board      = new();
    next_drain = 400;
    hold_done  = 1'b0;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_char   <= '0;
    in_at_end <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, escapes, hex widths and every error path
    send_item(CH_BIG_A, 1'b0);
    send_item(CH_MAX, 1'b0);
    send_item('0, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_QUOTE, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_LF, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_X, 1'b0);
    send_item(CH_FOUR, 1'b0); send_item(CH_A, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_BIG_U, 1'b0);
    for (int i = 0; i < 6; i++) send_item(i[0] ? CH_F : CH_BIG_F, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_Q, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_U, 1'b0); send_item(CH_G, 1'b0);
    send_item(CH_BSLASH, 1'b0); send_item(CH_MAX, 1'b1);
    send_item(CH_QUOTE, 1'b0);
    drain_results();

    while (items_sent < N_ITEMS) begin
      send_random_piece();
      if (!hold_done && items_sent > 500) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (items_sent >= next_drain) begin
        drain_results();
        next_drain += 400;
      end
    end

    in_valid <= 1'b0;
    while (board.pending_codes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    board.check_leftovers();
    if (board.fails == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
